### rtl/sme_pkg.sv
// sme_pkg: shared types and codes of the stack machine executor
// opcodes, status codes, value tags, controller states, command/status structs
// no dependencies
package sme_pkg;

    localparam logic [7:0] OP_PUSH = 8'd0;
    localparam logic [7:0] OP_ADD  = 8'd1;
    localparam logic [7:0] OP_SUB  = 8'd2;
    localparam logic [7:0] OP_MUL  = 8'd3;
    localparam logic [7:0] OP_DIV  = 8'd4;
    localparam logic [7:0] OP_EQ   = 8'd5;
    localparam logic [7:0] OP_LT   = 8'd6;
    localparam logic [7:0] OP_JMP  = 8'd7;
    localparam logic [7:0] OP_JMPF = 8'd8;
    localparam logic [7:0] OP_CALL = 8'd9;
    localparam logic [7:0] OP_RET  = 8'd10;

    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_RET    = 4'd1;
    localparam logic [3:0] ST_BADOP  = 4'd2;
    localparam logic [3:0] ST_UNDER  = 4'd3;
    localparam logic [3:0] ST_OVER   = 4'd4;
    localparam logic [3:0] ST_DIVZ   = 4'd5;
    localparam logic [3:0] ST_NATIVE = 4'd6;
    localparam logic [3:0] ST_ARGS   = 4'd7;
    localparam logic [3:0] ST_HALTED = 4'd8;

    localparam logic [1:0] TAG_NIL  = 2'd0;
    localparam logic [1:0] TAG_INT  = 2'd1;
    localparam logic [1:0] TAG_BOOL = 2'd2;

    localparam logic KIND_PRINT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [31:0] IMM_BYTES = 32'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD2,
        S_RD1,
        S_EXEC,
        S_MULDIV,
        S_JF,
        S_PRT,
        S_NIL,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {RD_TOP, RD_SECOND, RD_PRINT} rd_sel_t;
    typedef enum logic [1:0] {WR_CONST, WR_ALU, WR_NIL} wr_sel_t;
    typedef enum logic [2:0] {PC_HOLD, PC_ADD1, PC_ADD3, PC_ADD5, PC_JMP, PC_JMPF} pc_op_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_BASE1} cnt_op_t;

    typedef struct packed {
        logic       ld_item;
        rd_sel_t    rd_sel;
        logic       lat_b;
        logic       lat_a;
        logic       wr_en;
        wr_sel_t    wr_sel;
        cnt_op_t    cnt_op;
        pc_op_t     pc_op;
        logic       set_st;
        logic [3:0] st;
        logic       idx_clr;
        logic       idx_inc;
        logic       md_start;
        logic       out_print;
        logic       out_status;
    } cmd_t;

    typedef struct packed {
        logic [7:0] op;
        logic       cnt_full;
        logic       cnt_lt1;
        logic       cnt_lt2;
        logic       argc_zero;
        logic       argc_gt_max;
        logic       argc_gt_cnt;
        logic       nid_bad;
        logic       idx_last;
        logic       b_zero;
        logic       truth;
        logic       md_done;
        logic       out_free;
        logic       st_ok;
    } sts_t;

endpackage

### rtl/sme_if.sv
// sme_item_if / sme_result_if: valid-ready channels of the executor
// one beat moves one decoded instruction or one result
// no dependencies
interface sme_item_if;
    logic               valid;
    logic               ready;
    logic [7:0]         op;
    logic signed [63:0] const_value;
    logic signed [31:0] jump_offset;
    logic [7:0]         arg_count;
    logic [7:0]         native_id;

    modport source (output valid, op, const_value, jump_offset, arg_count, native_id,
                    input ready);
    modport sink   (input valid, op, const_value, jump_offset, arg_count, native_id,
                    output ready);
endinterface

interface sme_result_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [3:0]         status;
    logic signed [63:0] value;
    logic [1:0]         value_tag;
    logic [31:0]        next_pc;
    logic               last;

    modport source (output valid, kind, status, value, value_tag, next_pc, last,
                    input ready);
    modport sink   (input valid, kind, status, value, value_tag, next_pc, last,
                    output ready);
endinterface

### rtl/stack_machine_executor.sv
// Stack machine executor: runs one decoded instruction per item beat on a tagged
// 64-bit stack held in a single-port-read memory. Items are handled one at a time:
// push, jmp, ret and errors found at decode go from decode to the status beat, jmpf
// passes S_JF, add/sub/eq/lt and divide by zero read both operands first, mul runs
// on one 32x32 multiplier, div makes one quotient bit per cycle, and call sends one
// print beat per argument, then pushes nil; the memory delivers one entry per cycle.
// Result beats wait in an output register when the sink stalls. After ret or an
// error every item returns a halted status until reset. The stack needs no clearing pass.
module stack_machine_executor
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH     = 256,
    parameter int MAX_CALL_ARGS   = 63,
    parameter int PRINT_NATIVE_ID = 0
) (
    input logic          clk,
    input logic          rst_n,
    sme_item_if.sink     item,
    sme_result_if.source result
);

    cmd_t cmd;
    sts_t sts;

    sme_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    sme_dp #(
        .STACK_DEPTH     (STACK_DEPTH),
        .MAX_CALL_ARGS   (MAX_CALL_ARGS),
        .PRINT_NATIVE_ID (PRINT_NATIVE_ID)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (item.op),
        .const_value (item.const_value),
        .jump_offset (item.jump_offset),
        .arg_count   (item.arg_count),
        .native_id   (item.native_id),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_kind    (result.kind),
        .out_status  (result.status),
        .out_value   (result.value),
        .out_tag     (result.value_tag),
        .out_pc      (result.next_pc),
        .out_last    (result.last)
    );

endmodule

### rtl/sme_muldiv.sv
// sme_muldiv: iterative 64-bit wrapping multiply and truncating signed divide
// multiply reuses one 32x32 multiplier for its partial products, divide one bit per cycle
// no dependencies
module sme_muldiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_div,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    logic        busy_reg;
    logic        div_reg;
    logic        done_reg;
    logic [5:0]  step_reg;
    logic [63:0] q_reg;
    logic [63:0] d_reg;
    logic [63:0] rem_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic        neg_reg;
    logic [31:0] mx;
    logic [31:0] my;
    logic [64:0] trial;
    logic        ge;

    always_comb
    begin
        // operand a sits in q_reg, operand b in d_reg while multiplying
        case (step_reg[1:0])
            2'd1:    begin mx = q_reg[63:32]; my = d_reg[31:0];  end
            2'd2:    begin mx = q_reg[31:0];  my = d_reg[63:32]; end
            default: begin mx = q_reg[31:0];  my = d_reg[31:0];  end
        endcase
        trial = {rem_reg, q_reg[63]};
        ge    = trial >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                div_reg  <= is_div;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 6'd1;
                if ((div_reg && step_reg == 6'd63) || (!div_reg && step_reg == 6'd3))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (is_div)
            begin
                q_reg   <= a[63] ? 64'd0 - a : a;
                d_reg   <= b[63] ? 64'd0 - b : b;
                neg_reg <= a[63] ^ b[63];
                rem_reg <= '0;
            end
            else
            begin
                q_reg <= a;
                d_reg <= b;
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_reg <= ge ? 64'(trial - {1'b0, d_reg}) : trial[63:0];
                q_reg   <= {q_reg[62:0], ge};
            end
            else
            begin
                prod_reg <= 64'(mx * my);
                if (step_reg[1:0] == 2'd1)
                    acc_reg <= prod_reg;
                else if (step_reg[1:0] != 2'd0)
                    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
        end
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? 64'd0 - q_reg : q_reg) : acc_reg;

endmodule

### rtl/sme_dp.sv
// sme_dp: datapath of the executor: stack memory, counters, pc, operands, result register
// depends on sme_pkg and sme_muldiv
// acts only on commands from sme_ctrl
module sme_dp
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH     = 256,
    parameter int MAX_CALL_ARGS   = 63,
    parameter int PRINT_NATIVE_ID = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [7:0]         op,
    input  logic signed [63:0] const_value,
    input  logic signed [31:0] jump_offset,
    input  logic [7:0]         arg_count,
    input  logic [7:0]         native_id,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_kind,
    output logic [3:0]         out_status,
    output logic signed [63:0] out_value,
    output logic [1:0]         out_tag,
    output logic [31:0]        out_pc,
    output logic               out_last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [65:0]   stack_mem [STACK_DEPTH];
    logic [65:0]   rdata_reg;
    logic [7:0]    op_reg;
    logic [63:0]   cval_reg;
    logic [31:0]   off_reg;
    logic [7:0]    argc_reg;
    logic [7:0]    nid_reg;
    logic [63:0]   a_reg;
    logic [63:0]   b_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [31:0]   pc_reg;
    logic [31:0]   pc_next;
    logic [3:0]    st_reg;
    logic [5:0]    idx_reg;
    logic [5:0]    idx_next;
    logic [CW-1:0] base;
    logic [CW-1:0] rd_full;
    logic [CW-1:0] wr_full;
    logic [65:0]   wr_data;
    logic [63:0]   alu_val;
    logic [1:0]    alu_tag;
    logic          md_done;
    logic [63:0]   md_result;
    logic          out_valid_reg;
    logic          out_load;

    sme_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .is_div (op_reg == OP_DIV),
        .a      (a_reg),
        .b      (b_reg),
        .done   (md_done),
        .result (md_result)
    );

    always_comb
    begin
        base     = cnt_reg - CW'(argc_reg);
        idx_next = cmd.idx_clr ? 6'd0 : (cmd.idx_inc ? idx_reg + 6'd1 : idx_reg);

        case (cmd.rd_sel)
            RD_TOP:    rd_full = cnt_reg - CW'(1);
            RD_SECOND: rd_full = cnt_reg - CW'(2);
            default:   rd_full = base + CW'(idx_next);
        endcase

        case (op_reg)
            OP_ADD:  begin alu_val = a_reg + b_reg; alu_tag = TAG_INT; end
            OP_SUB:  begin alu_val = a_reg - b_reg; alu_tag = TAG_INT; end
            OP_EQ:   begin alu_val = {63'd0, a_reg == b_reg}; alu_tag = TAG_BOOL; end
            OP_LT:   begin alu_val = {63'd0, $signed(a_reg) < $signed(b_reg)};
                           alu_tag = TAG_BOOL; end
            default: begin alu_val = md_result; alu_tag = TAG_INT; end
        endcase

        case (cmd.wr_sel)
            WR_CONST: begin wr_full = cnt_reg;          wr_data = {TAG_INT, cval_reg}; end
            WR_ALU:   begin wr_full = cnt_reg - CW'(2); wr_data = {alu_tag, alu_val};  end
            default:  begin wr_full = base;             wr_data = {TAG_NIL, 64'd0};    end
        endcase

        case (cmd.cnt_op)
            CNT_INC:   cnt_next = cnt_reg + CW'(1);
            CNT_DEC:   cnt_next = cnt_reg - CW'(1);
            CNT_BASE1: cnt_next = base + CW'(1);
            default:   cnt_next = cnt_reg;
        endcase

        case (cmd.pc_op)
            PC_ADD1: pc_next = pc_reg + 32'd1;
            PC_ADD3: pc_next = pc_reg + 32'd3;
            PC_ADD5: pc_next = pc_reg + 32'd1 + IMM_BYTES;
            PC_JMP:  pc_next = pc_reg + 32'd1 + IMM_BYTES + off_reg;
            PC_JMPF: pc_next = pc_reg + 32'd1 + IMM_BYTES + (sts.truth ? 32'd0 : off_reg);
            default: pc_next = pc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= stack_mem[AW'(rd_full)];
        if (cmd.wr_en)
            stack_mem[AW'(wr_full)] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            op_reg   <= op;
            cval_reg <= const_value;
            off_reg  <= jump_offset;
            argc_reg <= arg_count;
            nid_reg  <= native_id;
        end
        if (cmd.lat_b)
            b_reg <= rdata_reg[63:0];
        if (cmd.lat_a)
            a_reg <= rdata_reg[63:0];
        if (cmd.set_st)
            st_reg <= cmd.st;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pc_reg  <= pc_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_load = cmd.out_print || cmd.out_status;

    // result register, a print beat carries the argument, a status beat the code
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind   <= cmd.out_status ? KIND_STATUS : KIND_PRINT;
            out_status <= cmd.out_status ? st_reg : ST_OK;
            out_value  <= cmd.out_status ? 64'd0 : rdata_reg[63:0];
            out_tag    <= cmd.out_status ? TAG_NIL : rdata_reg[65:64];
            out_pc     <= pc_reg;
            out_last   <= cmd.out_status;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        sts.op          = op_reg;
        sts.cnt_full    = cnt_reg >= CW'(STACK_DEPTH);
        sts.cnt_lt1     = cnt_reg < CW'(1);
        sts.cnt_lt2     = cnt_reg < CW'(2);
        sts.argc_zero   = argc_reg == 8'd0;
        sts.argc_gt_max = argc_reg > 8'(MAX_CALL_ARGS);
        sts.argc_gt_cnt = 16'(argc_reg) > 16'(cnt_reg);
        sts.nid_bad     = nid_reg != 8'(PRINT_NATIVE_ID);
        sts.idx_last    = {2'b00, idx_reg} == argc_reg - 8'd1;
        sts.b_zero      = b_reg == 64'd0;
        sts.truth       = rdata_reg[65:64] == TAG_BOOL && rdata_reg[63:0] != 64'd0;
        sts.md_done     = md_done;
        sts.out_free    = !out_valid_reg || out_ready;
        sts.st_ok       = st_reg == ST_OK;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_md_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |=> !md_done)
        else $error("muldiv done longer than one cycle");

endmodule

### rtl/sme_ctrl.sv
// sme_ctrl: instruction sequencer of the executor
// depends on sme_pkg; drives sme_dp through cmd_t and watches sts_t
module sme_ctrl
    import sme_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   halt_reg;
    logic   halt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            halt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            halt_reg  <= halt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        halt_next  = halt_reg;
        item_ready = 1'b0;
        cmd        = '0;
        cmd.rd_sel = RD_TOP;
        cmd.wr_sel = WR_CONST;
        cmd.cnt_op = CNT_HOLD;
        cmd.pc_op  = PC_HOLD;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.ld_item = item_valid;
                if (item_valid)
                    state_next = S_DECODE;
            end

            S_DECODE:
            begin
                cmd.set_st  = 1'b1;
                cmd.st      = ST_OK;
                state_next  = S_EMIT;
                if (halt_reg)
                    cmd.st = ST_HALTED;
                else
                begin
                    unique case (sts.op) inside
                        OP_PUSH:
                        begin
                            if (sts.cnt_full)
                                cmd.st = ST_OVER;
                            else
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = WR_CONST;
                                cmd.cnt_op = CNT_INC;
                                cmd.pc_op  = PC_ADD5;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT:
                        begin
                            if (sts.cnt_lt2)
                                cmd.st = ST_UNDER;
                            else
                                state_next = S_RD2;
                        end
                        OP_JMP:
                            cmd.pc_op = PC_JMP;
                        OP_JMPF:
                        begin
                            if (sts.cnt_lt1)
                                cmd.st = ST_UNDER;
                            else
                                state_next = S_JF;
                        end
                        OP_CALL:
                        begin
                            cmd.rd_sel  = RD_PRINT;
                            cmd.idx_clr = 1'b1;
                            if (sts.nid_bad)
                                cmd.st = ST_NATIVE;
                            else if (sts.argc_gt_max)
                                cmd.st = ST_ARGS;
                            else if (sts.argc_gt_cnt)
                                cmd.st = ST_UNDER;
                            else if (sts.argc_zero && sts.cnt_full)
                                cmd.st = ST_OVER;
                            else
                            begin
                                cmd.pc_op  = PC_ADD3;
                                state_next = sts.argc_zero ? S_NIL : S_PRT;
                            end
                        end
                        OP_RET:
                        begin
                            cmd.st    = ST_RET;
                            cmd.pc_op = PC_ADD1;
                        end
                        default:
                            cmd.st = ST_BADOP;
                    endcase
                end
            end

            S_RD2:
            begin
                cmd.lat_b  = 1'b1;
                cmd.rd_sel = RD_SECOND;
                state_next = S_RD1;
            end

            S_RD1:
            begin
                cmd.lat_a  = 1'b1;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                if (sts.op == OP_MUL || sts.op == OP_DIV)
                begin
                    if (sts.op == OP_DIV && sts.b_zero)
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_DIVZ;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.md_start = 1'b1;
                        state_next   = S_MULDIV;
                    end
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_ALU;
                    cmd.cnt_op = CNT_DEC;
                    cmd.pc_op  = PC_ADD1;
                    state_next = S_EMIT;
                end
            end

            S_MULDIV:
            begin
                if (sts.md_done)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_ALU;
                    cmd.cnt_op = CNT_DEC;
                    cmd.pc_op  = PC_ADD1;
                    state_next = S_EMIT;
                end
            end

            S_JF:
            begin
                cmd.cnt_op = CNT_DEC;
                cmd.pc_op  = PC_JMPF;
                state_next = S_EMIT;
            end

            // one beat per argument, the deepest argument first
            S_PRT:
            begin
                cmd.rd_sel = RD_PRINT;
                if (sts.out_free)
                begin
                    cmd.out_print = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    if (sts.idx_last)
                        state_next = S_NIL;
                end
            end

            S_NIL:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_NIL;
                cmd.cnt_op = CNT_BASE1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_status = 1'b1;
                    if (!sts.st_ok)
                        halt_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> state_reg == S_IDLE)
        else $error("item taken outside idle");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halt_reg) |-> halt_reg)
        else $error("halt cleared without reset");

    a_halt_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halt_reg) |-> $past(state_reg) == S_EMIT)
        else $error("halt set outside status emit");

endmodule

### dv/tb.sv
// tb: self-checking testbench of stack_machine_executor
// drives decoded instructions, predicts every result beat and compares them in order
// depends on rtl/sme_pkg.sv, rtl/sme_if.sv and rtl/stack_machine_executor.sv
`timescale 1ns / 1ps

module tb;
    import sme_pkg::*;

    localparam int DEPTH      = 256;
    localparam int MAX_ARGS   = 63;
    localparam int PRINT_ID   = 0;
    localparam int RAND_ITEMS = 330;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic [7:0]  op;
        logic [63:0] cval;
        logic [31:0] offs;
        logic [7:0]  argc;
        logic [7:0]  nid;
        bit          hold;
    } instr_t;

    typedef struct {
        logic        kind;
        logic [3:0]  status;
        logic [63:0] value;
        logic [1:0]  tag;
        logic [31:0] pc;
        logic        last;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sme_item_if   item ();
    sme_result_if result ();

    stack_machine_executor DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    always #2 clk = ~clk;

    instr_t pending_instr[$];
    beat_t  expected_beats[$];
    int     instr_total;
    int     instr_sent;
    int     mismatches;
    int     gen_depth;
    int     quiet_cycles;

    // predictor state
    logic [63:0] pred_vals[DEPTH];
    logic [1:0]  pred_tags[DEPTH];
    int          pred_count;
    logic [31:0] pred_pc;
    bit          pred_halted;

    function automatic int sender_idle_pct();
        case ((instr_sent * 4) / (instr_total + 1))
            1:       return 50;
            3:       return 16;
            default: return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case ((instr_sent * 4) / (instr_total + 1))
            2:       return 50;
            3:       return 16;
            default: return 0;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7fff_ffff_ffff_ffff;
            2: v = 64'hffff_ffff_ffff_ffff;
            3: v = 64'($urandom_range(0, 20)) - 64'd10;
            default: ;
        endcase
        return v;
    endfunction

    function automatic void add_beat(logic kind, logic [3:0] st, logic [63:0] val,
                                     logic [1:0] tag, logic [31:0] pc, logic last);
        beat_t b;
        b.kind = kind; b.status = st; b.value = val; b.tag = tag; b.pc = pc; b.last = last;
        expected_beats.push_back(b);
    endfunction

    function automatic void step_machine(instr_t it);
        logic [63:0] a, b, r;
        logic [1:0]  tg;
        logic [3:0]  st;
        logic [31:0] npc;
        int          base;
        bit          truth;
        npc = pred_pc;
        st  = ST_OK;
        if (pred_halted) begin
            add_beat(KIND_STATUS, ST_HALTED, '0, TAG_NIL, pred_pc, 1'b1);
            return;
        end
        case (it.op) inside
            OP_PUSH: begin
                if (pred_count >= DEPTH) st = ST_OVER;
                else begin
                    pred_vals[pred_count] = it.cval;
                    pred_tags[pred_count] = TAG_INT;
                    pred_count++;
                    npc = npc + 32'd1 + IMM_BYTES;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT: begin
                if (pred_count < 2) st = ST_UNDER;
                else begin
                    a  = pred_vals[pred_count - 2];
                    b  = pred_vals[pred_count - 1];
                    tg = TAG_INT;
                    r  = '0;
                    case (it.op)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        OP_DIV: begin
                            if (b == 0) st = ST_DIVZ;
                            else if (b == 64'hffff_ffff_ffff_ffff) r = 64'd0 - a;
                            else r = $signed(a) / $signed(b);
                        end
                        OP_EQ: begin r = {63'd0, a == b}; tg = TAG_BOOL; end
                        default: begin r = {63'd0, $signed(a) < $signed(b)}; tg = TAG_BOOL; end
                    endcase
                    if (st == ST_OK) begin
                        pred_count--;
                        pred_vals[pred_count - 1] = r;
                        pred_tags[pred_count - 1] = tg;
                        npc = npc + 32'd1;
                    end
                end
            end
            OP_JMP: npc = npc + 32'd1 + IMM_BYTES + it.offs;
            OP_JMPF: begin
                if (pred_count < 1) st = ST_UNDER;
                else begin
                    pred_count--;
                    truth = pred_tags[pred_count] == TAG_BOOL && pred_vals[pred_count] != 0;
                    npc = npc + 32'd1 + IMM_BYTES;
                    if (!truth) npc = npc + it.offs;
                end
            end
            OP_CALL: begin
                if (it.nid != PRINT_ID) st = ST_NATIVE;
                else if (it.argc > MAX_ARGS) st = ST_ARGS;
                else if (it.argc > pred_count) st = ST_UNDER;
                else if (it.argc == 0 && pred_count >= DEPTH) st = ST_OVER;
                else begin
                    npc  = npc + 32'd3;
                    base = pred_count - it.argc;
                    for (int i = 0; i < it.argc; i++)
                        add_beat(KIND_PRINT, ST_OK, pred_vals[base + i],
                                 pred_tags[base + i], npc, 1'b0);
                    pred_count = base;
                    pred_vals[pred_count] = '0;
                    pred_tags[pred_count] = TAG_NIL;
                    pred_count++;
                end
            end
            OP_RET: begin
                st  = ST_RET;
                npc = npc + 32'd1;
            end
            default: st = ST_BADOP;
        endcase
        if (st != ST_OK) pred_halted = 1'b1;
        pred_pc = npc;
        add_beat(KIND_STATUS, st, '0, TAG_NIL, npc, 1'b1);
    endfunction

    // queue one instruction; the wrappers below fill fields it does not use with random noise
    task automatic queue_instr(logic [7:0] op, logic [63:0] cval, logic [31:0] offs,
                               logic [7:0] argc, logic [7:0] nid);
        instr_t it;
        it.op = op; it.cval = cval; it.offs = offs; it.argc = argc; it.nid = nid;
        it.hold = 1'b0;
        pending_instr.push_back(it);
        case (op) inside
            OP_PUSH: gen_depth++;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_JMPF: gen_depth--;
            OP_CALL: gen_depth = gen_depth - argc + 1;
            default: ;
        endcase
    endtask

    task automatic queue_push(logic [63:0] v);
        queue_instr(OP_PUSH, v, $urandom, $urandom, $urandom);
    endtask

    task automatic queue_op(logic [7:0] op);
        queue_instr(op, rand64(), $urandom, $urandom, $urandom);
    endtask

    task automatic queue_print(int n);
        queue_instr(OP_CALL, rand64(), $urandom, 8'(n), 8'(PRINT_ID));
    endtask

    task automatic build_stimulus();
        int r, n;
        logic [63:0] d;
        bit hold_done;
        hold_done = 1'b0;
        // directed: extremes, truncating division, min / -1, bools, jumps, prints
        queue_push(64'h7fff_ffff_ffff_ffff);
        queue_push(64'h8000_0000_0000_0000);
        queue_op(OP_LT);
        queue_instr(OP_JMPF, '0, 32'h7fff_ffff, '0, '0);
        queue_push(64'h8000_0000_0000_0000);
        queue_push(64'hffff_ffff_ffff_ffff);
        queue_op(OP_DIV);
        queue_push(-64'sd7);
        queue_push(64'd2);
        queue_op(OP_DIV);
        queue_push(64'h7fff_ffff_ffff_ffff);
        queue_op(OP_ADD);
        queue_op(OP_EQ);
        queue_instr(OP_JMPF, '0, 32'h8000_0000, '0, '0);
        queue_push(64'd3);
        queue_push(64'hffff_ffff_ffff_ffff);
        queue_op(OP_MUL);
        queue_push(64'd9);
        queue_op(OP_SUB);
        queue_instr(OP_JMP, '0, 32'h8000_0000, '0, '0);
        queue_instr(OP_JMP, '0, 32'h7fff_ffff, '0, '0);
        queue_push(64'd5);
        queue_push(64'd5);
        queue_op(OP_EQ);
        queue_print(gen_depth);
        queue_print(0);
        // random well-formed program
        while (pending_instr.size() < RAND_ITEMS) begin
            if (!hold_done && pending_instr.size() >= RAND_ITEMS / 2) begin
                queue_op(OP_JMP);
                pending_instr[pending_instr.size() - 1].hold = 1'b1;
                hold_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (gen_depth < 2 && r >= 30 && r < 55) r = 0;
            if (gen_depth < 1 && r >= 55 && r < 80 && r >= 70) r = 0;
            if (r < 30) begin
                if (gen_depth < DEPTH) queue_push(rand64());
                else queue_op(OP_ADD);
            end else if (r < 55) begin
                case ($urandom_range(0, 4))
                    0: queue_op(OP_ADD);
                    1: queue_op(OP_SUB);
                    2: queue_op(OP_MUL);
                    3: queue_op(OP_EQ);
                    default: queue_op(OP_LT);
                endcase
            end else if (r < 62) begin
                if (gen_depth >= DEPTH) queue_op(OP_ADD);
                if (gen_depth < 1) queue_push(rand64());
                d = rand64();
                if (d == 0) d = 64'd1;
                queue_push(d);
                queue_op(OP_DIV);
            end else if (r < 70) begin
                queue_instr(OP_JMP, rand64(), $urandom, $urandom, $urandom);
            end else if (r < 80) begin
                if (gen_depth < 1) queue_push(rand64());
                queue_instr(OP_JMPF, rand64(), $urandom, $urandom, $urandom);
            end else begin
                n = $urandom_range(0, (gen_depth < MAX_ARGS) ? gen_depth : MAX_ARGS);
                if ($urandom_range(0, 9) == 0)
                    n = (gen_depth < MAX_ARGS) ? gen_depth : MAX_ARGS;
                if (n == 0 && gen_depth >= DEPTH) n = 1;
                queue_print(n);
            end
        end
        // one ending per run: the block halts until reset afterwards
        case ($urandom_range(0, 6))
            0: queue_op(OP_RET);
            1: queue_instr(8'($urandom_range(11, 255)), rand64(), $urandom, $urandom, $urandom);
            2: begin
                while (gen_depth > MAX_ARGS - 1) queue_print(MAX_ARGS);
                queue_print(gen_depth + 1);
            end
            3: begin
                if (gen_depth < 1) queue_push(rand64());
                queue_push(64'd0);
                queue_op(OP_DIV);
            end
            4: queue_instr(OP_CALL, rand64(), $urandom, $urandom,
                           8'($urandom_range(1, 255)));
            5: queue_instr(OP_CALL, rand64(), $urandom, 8'($urandom_range(MAX_ARGS + 1, 255)),
                           8'(PRINT_ID));
            default: begin
                while (gen_depth < DEPTH) queue_push(rand64());
                if ($urandom_range(0, 1)) queue_push(rand64());
                else queue_print(0);
            end
        endcase
        // halted: any content, every bit of every field toggles here
        queue_instr('1, '1, '1, '1, '1);
        queue_instr('0, '0, '0, '0, '0);
        repeat (10) queue_instr($urandom, rand64(), $urandom, $urandom, $urandom);
        instr_total = pending_instr.size();
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin : drive_items
        bit fire;
        if (!rst_n) begin
            item.valid <= 1'b0;
        end else begin
            fire = item.valid && item.ready;
            if (fire) begin
                step_machine(pending_instr[0]);
                pending_instr.pop_front();
                instr_sent++;
            end
            if (item.valid && !fire) begin
                // hold the beat until accepted
            end else if (pending_instr.size() > 0
                         && !(pending_instr[0].hold && expected_beats.size() > 0)
                         && $urandom_range(0, 99) >= sender_idle_pct()) begin
                item.valid       <= 1'b1;
                item.op          <= pending_instr[0].op;
                item.const_value <= pending_instr[0].cval;
                item.jump_offset <= pending_instr[0].offs;
                item.arg_count   <= pending_instr[0].argc;
                item.native_id   <= pending_instr[0].nid;
            end else begin
                item.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin : check_results
        beat_t exp_b;
        if (!rst_n) begin
            result.ready <= 1'b0;
        end else begin
            if (result.valid && result.ready) begin
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: kind %0d status %0d pc %h",
                                 result.kind, result.status, result.next_pc);
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (result.kind !== exp_b.kind || result.status !== exp_b.status
                        || result.value !== exp_b.value || result.value_tag !== exp_b.tag
                        || result.next_pc !== exp_b.pc || result.last !== exp_b.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp kind %0d st %0d val %h tag %0d",
                                     exp_b.kind, exp_b.status, exp_b.value, exp_b.tag,
                                     " pc %h last %0d,", exp_b.pc, exp_b.last,
                                     " got kind %0d st %0d val %h tag %0d",
                                     result.kind, result.status, result.value,
                                     result.value_tag,
                                     " pc %h last %0d", result.next_pc, result.last);
                    end
                end
            end
            result.ready <= ($urandom_range(0, 99) >= sink_stall_pct());
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((item.valid && item.ready) || (result.valid && result.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        item.valid       = 1'b0;
        item.op          = '0;
        item.const_value = '0;
        item.jump_offset = '0;
        item.arg_count   = '0;
        item.native_id   = '0;
        result.ready     = 1'b0;
        instr_sent   = 0;
        mismatches   = 0;
        gen_depth    = 0;
        quiet_cycles = 0;
        pred_count   = 0;
        pred_pc      = '0;
        pred_halted  = 1'b0;
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_instr.size() == 0 && !item.valid);
        wait (expected_beats.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
